// ----- hw/rtl/crz_pkg.sv -----
// ---------------------------------------------------------------------------
// crz_pkg: shared types and constants of the circle rasterizer
// Widths, opcodes, the group snapshot handed from the iteration logic to the
// result sequencer, and the coordinate output conversion.
// ---------------------------------------------------------------------------
package crz_pkg;

  localparam int RADIUS_BITS = 12;
  localparam int COORD_BITS  = 16;
  localparam int CENTER_W    = 15;
  localparam int OUT_W       = 16;
  localparam int OFS_W       = RADIUS_BITS + 1;
  localparam int DEC_W       = RADIUS_BITS + 3;
  localparam int CALC_W      = DEC_W + 1;
  localparam int IDX_W       = 3;

  localparam logic [IDX_W-1:0] OUTLINE_LAST = IDX_W'(7);
  localparam logic [IDX_W-1:0] FILL_LAST    = IDX_W'(3);

  typedef enum logic {
    OP_START   = 1'b0,
    OP_ADVANCE = 1'b1
  } op_t;

  typedef logic signed [CENTER_W-1:0]   center_t;
  typedef logic signed [OFS_W-1:0]      offset_t;
  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [OUT_W-1:0]      out_coord_t;

  // snapshot of one iteration, taken when the advance is accepted
  typedef struct packed {
    center_t cx;
    center_t cy;
    offset_t ox;
    offset_t oy;
    logic    fill;
    logic    done;
  } group_t;

  // sequencer status seen by the top level
  typedef struct packed {
    logic             ready;
    logic             busy;
    logic             fill;
    logic [IDX_W-1:0] idx;
  } emit_stat_t;

  // wrapped coordinate to the output width, sign-extended or truncated
  function automatic out_coord_t to_out(coord_t v);
    return OUT_W'(v);
  endfunction

endpackage

// ----- hw/rtl/crz_state.sv -----
// ---------------------------------------------------------------------------
// crz_state: circle state and decision update
// Holds centre, radius, offsets, decision variable and mode; runs one
// iteration of the three-way update per accepted advance on a running circle.
// ---------------------------------------------------------------------------
module crz_state (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic                             cfg_wr_data,
  input  logic                             accept,
  input  logic                             op,
  input  crz_pkg::center_t                 center_x,
  input  crz_pkg::center_t                 center_y,
  input  logic [crz_pkg::RADIUS_BITS-1:0]  radius,
  output logic                             grp_load,
  output crz_pkg::group_t                  grp
);
  import crz_pkg::*;

  localparam logic signed [CALC_W-1:0] ONE_C = CALC_W'(1);

  logic                   fill_mode_r;
  logic                   active_r;
  center_t                centre_x_r;
  center_t                centre_y_r;
  logic [RADIUS_BITS-1:0] radius_r;
  offset_t                offset_x_r, offset_x_nxt;
  offset_t                offset_y_r, offset_y_nxt;
  logic signed [DEC_W-1:0] decision_r, decision_nxt;

  logic signed [CALC_W-1:0] ox_c, oy_c, dec_c, rad_c, two_ox_c, dec_upd_c;
  logic                     done_c;

  // widen the state for the compare and update arithmetic
  assign ox_c     = CALC_W'(offset_x_r);
  assign oy_c     = CALC_W'(offset_y_r);
  assign dec_c    = CALC_W'(decision_r);
  assign rad_c    = signed'(CALC_W'(radius_r));
  assign two_ox_c = ox_c + ox_c;

  // three-way decision step
  always_comb begin
    offset_x_nxt = offset_x_r;
    offset_y_nxt = offset_y_r;
    dec_upd_c    = dec_c;
    priority if (dec_c >= two_ox_c) begin
      dec_upd_c    = dec_c - two_ox_c - ONE_C;
      offset_x_nxt = OFS_W'(ox_c + ONE_C);
    end else if (dec_c < ((rad_c - oy_c) + (rad_c - oy_c))) begin
      dec_upd_c    = dec_c + oy_c + oy_c - ONE_C;
      offset_y_nxt = OFS_W'(oy_c - ONE_C);
    end else begin
      dec_upd_c    = dec_c + ((oy_c - ox_c - ONE_C) + (oy_c - ox_c - ONE_C));
      offset_y_nxt = OFS_W'(oy_c - ONE_C);
      offset_x_nxt = OFS_W'(ox_c + ONE_C);
    end
    decision_nxt = DEC_W'(dec_upd_c);
  end

  assign done_c   = offset_y_nxt < offset_x_nxt;
  assign grp_load = accept && (op == OP_ADVANCE) && active_r;

  assign grp.cx   = centre_x_r;
  assign grp.cy   = centre_y_r;
  assign grp.ox   = offset_x_r;
  assign grp.oy   = offset_y_r;
  assign grp.fill = fill_mode_r;
  assign grp.done = done_c;

  // load on start, step on advance, drop to idle after the final iteration; a config write sets the fill mode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_mode_r <= 1'b0;
      active_r    <= 1'b0;
      centre_x_r  <= '0;
      centre_y_r  <= '0;
      radius_r    <= '0;
      offset_x_r  <= '0;
      offset_y_r  <= '0;
      decision_r  <= '0;
    end else begin
      if (cfg_wr_en) begin
        fill_mode_r <= cfg_wr_data;
      end
      if (accept && (op == OP_START)) begin
        centre_x_r <= center_x;
        centre_y_r <= center_y;
        radius_r   <= radius;
        offset_x_r <= '0;
        offset_y_r <= OFS_W'(radius);
        decision_r <= DEC_W'(radius) - DEC_W'(1);
        active_r   <= 1'b1;
      end else if (grp_load) begin
        offset_x_r <= offset_x_nxt;
        offset_y_r <= offset_y_nxt;
        decision_r <= decision_nxt;
        active_r   <= !done_c;
      end
    end
  end

endmodule

// ----- hw/rtl/crz_emit.sv -----
// ---------------------------------------------------------------------------
// crz_emit: result sequencer and output register
// Holds one iteration's snapshot and walks its points or spans into a
// registered output stage, one result transaction per cycle unless stalled.
// ---------------------------------------------------------------------------
module crz_emit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  grp_load,
  input  crz_pkg::group_t       grp_in,
  input  logic                  out_ready,
  output logic                  out_valid,
  output crz_pkg::out_coord_t   out_x_first,
  output crz_pkg::out_coord_t   out_x_last,
  output crz_pkg::out_coord_t   out_y_pos,
  output logic                  out_group_end,
  output logic                  out_circle_done,
  output crz_pkg::emit_stat_t   stat
);
  import crz_pkg::*;

  logic             busy_r;
  logic [IDX_W-1:0] idx_r;
  group_t           grp_r;
  logic             out_valid_r;
  out_coord_t       x_first_r, x_last_r, y_pos_r;
  logic             group_end_r, circle_done_r;

  logic   last_c, load_out;
  coord_t cx, cy, ox, oy;
  coord_t x_pox, x_mox, x_poy, x_moy, y_pox, y_mox, y_poy, y_moy;
  coord_t xf_c, xl_c, y_c;

  assign last_c   = grp_r.fill ? (idx_r == FILL_LAST) : (idx_r == OUTLINE_LAST);
  assign load_out = busy_r && (!out_valid_r || out_ready);

  // coordinate sums, wrapping at the coordinate width
  assign cx    = COORD_BITS'(grp_r.cx);
  assign cy    = COORD_BITS'(grp_r.cy);
  assign ox    = COORD_BITS'(grp_r.ox);
  assign oy    = COORD_BITS'(grp_r.oy);
  assign x_pox = cx + ox;
  assign x_mox = cx - ox;
  assign x_poy = cx + oy;
  assign x_moy = cx - oy;
  assign y_pox = cy + ox;
  assign y_mox = cy - ox;
  assign y_poy = cy + oy;
  assign y_moy = cy - oy;

  // pick the current point or span
  always_comb begin
    xf_c = x_pox;
    xl_c = x_pox;
    y_c  = y_poy;
    if (grp_r.fill) begin
      unique case (idx_r)
        IDX_W'(0): begin xf_c = x_moy; xl_c = x_poy; y_c = y_pox; end
        IDX_W'(1): begin xf_c = x_mox; xl_c = x_pox; y_c = y_poy; end
        IDX_W'(2): begin xf_c = x_mox; xl_c = x_pox; y_c = y_moy; end
        default:   begin xf_c = x_moy; xl_c = x_poy; y_c = y_mox; end
      endcase
    end else begin
      unique case (idx_r)
        IDX_W'(0): begin xf_c = x_pox; y_c = y_poy; end
        IDX_W'(1): begin xf_c = x_poy; y_c = y_pox; end
        IDX_W'(2): begin xf_c = x_mox; y_c = y_poy; end
        IDX_W'(3): begin xf_c = x_moy; y_c = y_pox; end
        IDX_W'(4): begin xf_c = x_pox; y_c = y_moy; end
        IDX_W'(5): begin xf_c = x_poy; y_c = y_mox; end
        IDX_W'(6): begin xf_c = x_mox; y_c = y_moy; end
        default:   begin xf_c = x_moy; y_c = y_mox; end
      endcase
      xl_c = xf_c;
    end
  end

  // group control: take a new snapshot as the old one hands out its last result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (grp_load) begin
        busy_r <= 1'b1;
        idx_r  <= '0;
      end else if (load_out) begin
        busy_r <= !last_c;
        idx_r  <= idx_r + IDX_W'(1);
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload: snapshot and output register
  always_ff @(posedge clk) begin
    if (grp_load) begin
      grp_r <= grp_in;
    end
    if (load_out) begin
      x_first_r     <= to_out(xf_c);
      x_last_r      <= to_out(xl_c);
      y_pos_r       <= to_out(y_c);
      group_end_r   <= last_c;
      circle_done_r <= grp_r.done;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_x_first     = x_first_r;
  assign out_x_last      = x_last_r;
  assign out_y_pos       = y_pos_r;
  assign out_group_end   = group_end_r;
  assign out_circle_done = circle_done_r;

  assign stat.ready = !busy_r || (load_out && last_c);
  assign stat.busy  = busy_r;
  assign stat.fill  = grp_r.fill;
  assign stat.idx   = idx_r;

endmodule

// ----- hw/rtl/circle_rasterizer_unit.sv -----
// ---------------------------------------------------------------------------
// circle_rasterizer_unit: integer circle rasterizer
// Start transactions load a circle; advance transactions each run one
// iteration and produce a group of outline points or filled spans.
// ---------------------------------------------------------------------------
// A start transaction produces nothing. An advance transaction on a running
// circle produces 8 one-pixel results in outline mode or 4 horizontal spans
// in fill mode, one result per cycle from the output register while the
// consumer does not stall; the next transaction is accepted in the cycle
// the group's last result is loaded into the output register. The decision
// step itself is done in the accepting cycle. An advance with no circle
// running is consumed without results. fill_mode is sampled when an advance
// is accepted; write it only while the block is idle.
module circle_rasterizer_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic                             cfg_wr_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_op,
  input  crz_pkg::center_t                 in_center_x,
  input  crz_pkg::center_t                 in_center_y,
  input  logic [crz_pkg::RADIUS_BITS-1:0]  in_radius,
  output logic                             out_valid,
  input  logic                             out_ready,
  output crz_pkg::out_coord_t              out_x_first,
  output crz_pkg::out_coord_t              out_x_last,
  output crz_pkg::out_coord_t              out_y_pos,
  output logic                             out_group_end,
  output logic                             out_circle_done
);
  import crz_pkg::*;

  logic       in_accept;
  logic       grp_load;
  group_t     grp;
  emit_stat_t emit_stat;

  assign in_ready  = emit_stat.ready;
  assign in_accept = in_valid && in_ready;

  // circle state and iteration step
  crz_state u_state (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .accept      (in_accept),
    .op          (in_op),
    .center_x    (in_center_x),
    .center_y    (in_center_y),
    .radius      (in_radius),
    .grp_load    (grp_load),
    .grp         (grp)
  );

  // result sequencing
  crz_emit u_emit (
    .clk             (clk),
    .rst_n           (rst_n),
    .grp_load        (grp_load),
    .grp_in          (grp),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_x_first     (out_x_first),
    .out_x_last      (out_x_last),
    .out_y_pos       (out_y_pos),
    .out_group_end   (out_group_end),
    .out_circle_done (out_circle_done),
    .stat            (emit_stat)
  );

`ifndef SYNTHESIS
  // a group runs on without a gap once a non-final result is taken
  a_group_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_group_end) |=> out_valid)
    else $error("result group broke off before its last result");

  // a fill group never walks past its fourth span
  a_fill_index: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_stat.busy && emit_stat.fill) |-> (emit_stat.idx <= FILL_LAST))
    else $error("fill group index out of range");

  // a start never launches a result group
  a_start_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && (in_op == OP_START)) |-> !grp_load)
    else $error("start transaction launched a result group");
`endif

endmodule
